>>> rtl/core/dotq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the deadline-ordered timer queue.
// Depends on nothing; every other file of the block imports it.
package dotq_pkg;

  localparam int TASK_BITS   = 8;
  localparam int TIME_BITS   = 48;
  localparam int TMO_BITS    = 31;
  localparam int MAX_RESULTS = 16;
  localparam int POP_BITS    = $clog2(MAX_RESULTS + 1);

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_FIRE     = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [TASK_BITS-1:0] task_id;
    logic [TMO_BITS-1:0]  timeout_ms;
    logic [TIME_BITS-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic                 task_valid;
    logic [TASK_BITS-1:0] ready_task;
    logic                 rearm;
    logic [TIME_BITS-1:0] next_delay_ms;
    logic                 armed;
    logic                 rejected;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] dl;
    logic [TASK_BITS-1:0] tid;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

>>> rtl/core/deadline_ordered_timer_queue_unit.sv
`timescale 1ns / 1ps
// Deadline-ordered timer queue: top level with sequencer and cell chain.
// Depends on dotq_pkg and dotq_cell.
//
// Usage: drive cmd_i and raise start; a transaction is taken at a rising edge
// with start high and busy low. op schedule adds task_id with deadline
// now_ms + timeout_ms (saturated) into a chain of CAPACITY cells kept in
// deadline order, ties in arrival order. op fire releases due tasks from the
// head of the chain, one per cycle, at most MAX_RESULTS per transaction.
// Each result appears on res_o for one cycle with res_valid_o high; the
// receiver cannot stall, so results are never held. The final result of a
// transaction has last set and carries the timer report.
// Sequence: a schedule registers the saturated deadline, then inserts it
// across all cells at once in ST_INS; a fire releases one task per cycle
// from the head by a single pop in ST_POP. A result is registered and shows
// in the cycle after the cycle that computed it; busy drops in that cycle,
// so the next transaction can overlap the result output.
// Reset clears the fill count, the armed flag and the sequencer; cell
// contents are not cleared, since only slots below the fill count are used.
module deadline_ordered_timer_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  dotq_pkg::cmd_t   cmd_i,
  output logic             busy,
  output logic             res_valid_o,
  output dotq_pkg::res_t   res_o
);
  import dotq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_INS  = 3'b010,
    ST_POP  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 armed_q, armed_d;
  logic [POP_BITS-1:0]  pop_cnt_q, pop_cnt_d;
  logic                 few_q, few_d;
  logic [TIME_BITS-1:0] dl_q, dl_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [TASK_BITS-1:0] tid_q, tid_d;
  res_t                 res_q, res_d;
  logic                 res_valid_q, res_valid_d;

  cell_ctl_t            ctl;
  logic [TIME_BITS-1:0] key;
  entry_t               entry_w [CAPACITY];
  logic [CAPACITY-1:0]  gt_w;
  entry_t               new_entry;

  logic [TIME_BITS:0]   sum_w;
  logic [TIME_BITS-1:0] new_sub, head_sub, sec_sub;
  logic                 head_later;
  logic                 all_due;
  logic [CW-1:0]        rem;
  logic                 head_due, next_due;

  assign new_entry = '{dl: dl_q, tid: tid_q};

  // Cell chain: cell 0 is the head (earliest deadline).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_gt;
    if (i == 0) begin : g_head
      assign prev_e  = '0;
      assign prev_gt = 1'b0;
    end else begin : g_body
      assign prev_e  = entry_w[i-1];
      assign prev_gt = gt_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = entry_w[i+1];
    end
    dotq_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .key_i     (key),
      .new_i     (new_entry),
      .occ_i     (cnt_q > CW'(i)),
      .prev_gt_i (prev_gt),
      .prev_i    (prev_e),
      .next_i    (next_e),
      .entry_o   (entry_w[i]),
      .gt_o      (gt_w[i])
    );
  end

  // Saturating deadline add at accept time.
  assign sum_w = {1'b0, cmd_i.now_ms} + (TIME_BITS + 1)'(cmd_i.timeout_ms);

  // Delay candidates, computed in parallel with the chain compares.
  assign new_sub    = dl_q - now_q;
  assign head_sub   = entry_w[0].dl - now_q;
  assign sec_sub    = entry_w[1].dl - now_q;
  assign head_later = entry_w[0].dl > now_q;

  // During a fire the key is now, so no occupied cell later than now means
  // every stored task is due.
  assign all_due  = ~|gt_w;
  assign rem      = cnt_q - CW'(1);
  assign head_due = (cnt_q != '0) && (pop_cnt_q < POP_BITS'(MAX_RESULTS)) && !gt_w[0];
  assign next_due = (rem != '0) && (pop_cnt_q < POP_BITS'(MAX_RESULTS - 1)) && !gt_w[1];

  // Compare against the new deadline while inserting, against now otherwise.
  assign key = (state_q == ST_INS) ? dl_q : now_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    armed_d     = armed_q;
    pop_cnt_d   = pop_cnt_q;
    few_d       = few_q;
    dl_d        = dl_q;
    now_d       = now_q;
    tid_d       = tid_q;
    ctl         = '0;
    res_d       = '0;
    res_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          // Capture the transaction and the saturated deadline.
          dl_d      = sum_w[TIME_BITS] ? '1 : sum_w[TIME_BITS-1:0];
          now_d     = cmd_i.now_ms;
          tid_d     = cmd_i.task_id;
          few_d     = int'(cnt_q) <= MAX_RESULTS;
          pop_cnt_d = '0;
          state_d   = (cmd_i.op == OP_FIRE) ? ST_POP : ST_INS;
        end
      end

      ST_INS: begin
        res_valid_d = 1'b1;
        res_d.last  = 1'b1;
        state_d     = ST_IDLE;
        if (cnt_q == CW'(CAPACITY)) begin
          // Drop the schedule; state holds.
          res_d.rejected = 1'b1;
          res_d.armed    = armed_q;
        end else begin
          ctl.ins = 1'b1;
          cnt_d   = cnt_q + CW'(1);
          // gt_w[0] means the new deadline is earlier than the stored head.
          if (!armed_q || (cnt_q == '0) || gt_w[0]) begin
            armed_d     = 1'b1;
            res_d.rearm = 1'b1;
            if ((cnt_q == '0) || gt_w[0]) begin
              res_d.next_delay_ms = new_sub;
            end else begin
              res_d.next_delay_ms = head_later ? head_sub : '0;
            end
          end
          res_d.armed = armed_d;
        end
      end

      ST_POP: begin
        res_valid_d = 1'b1;
        if (head_due) begin
          // Release the head and shift the chain forward.
          ctl.pop          = 1'b1;
          cnt_d            = rem;
          pop_cnt_d        = pop_cnt_q + POP_BITS'(1);
          res_d.task_valid = 1'b1;
          res_d.ready_task = entry_w[0].tid;
          if (!next_due) begin
            res_d.last          = 1'b1;
            res_d.rearm         = (rem != '0);
            res_d.next_delay_ms = ((rem != '0) && gt_w[1]) ? sec_sub : '0;
            res_d.armed         = (rem != '0);
            armed_d             = (rem != '0);
            state_d             = ST_IDLE;
          end else begin
            res_d.armed = !(few_q && all_due);
          end
        end else begin
          // Nothing due: one report result.
          res_d.last          = 1'b1;
          res_d.rearm         = (cnt_q != '0);
          res_d.next_delay_ms = ((cnt_q != '0) && gt_w[0]) ? head_sub : '0;
          res_d.armed         = (cnt_q != '0);
          armed_d             = (cnt_q != '0);
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      armed_q     <= 1'b0;
      pop_cnt_q   <= '0;
      few_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      armed_q     <= armed_d;
      pop_cnt_q   <= pop_cnt_d;
      few_q       <= few_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dl_q  <= dl_d;
    now_q <= now_d;
    tid_q <= tid_d;
    res_q <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Fill count never exceeds the chain length.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= CAPACITY)
    else $error("fill count above capacity");

  // The timer is armed exactly when tasks are pending.
  a_armed_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q == (cnt_q != '0))
    else $error("armed flag disagrees with fill count");

  // The final result of a transaction coincides with the sequencer going idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.last == !busy))
    else $error("last flag out of step with sequencer");

  // A rejected schedule releases nothing and ends the transaction.
  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.rejected) |-> (!res_o.task_valid && res_o.last && !res_o.rearm))
    else $error("malformed reject result");

  // An accepted transaction always leaves the sequencer busy in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction not started");

endmodule

>>> rtl/core/dotq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted deadline chain: holds an entry, compares it with the
// broadcast key, shifts toward the tail on insert and toward the head on pop.
// Depends on dotq_pkg.
module dotq_cell (
  input  logic                        clk_i,
  input  dotq_pkg::cell_ctl_t         ctl_i,
  input  logic [dotq_pkg::TIME_BITS-1:0] key_i,
  input  dotq_pkg::entry_t            new_i,
  input  logic                        occ_i,
  input  logic                        prev_gt_i,
  input  dotq_pkg::entry_t            prev_i,
  input  dotq_pkg::entry_t            next_i,
  output dotq_pkg::entry_t            entry_o,
  output logic                        gt_o
);
  import dotq_pkg::*;

  entry_t entry_q, entry_d;

  // occupied and strictly later than the key
  assign gt_o = occ_i && (entry_q.dl > key_i);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (prev_gt_i) begin
        entry_d = prev_i;
      end else if (gt_o || !occ_i) begin
        entry_d = new_i;
      end
    end else if (ctl_i.pop) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> sim/tb_deadline_ordered_timer_queue_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for deadline_ordered_timer_queue_unit.
// Depends on dotq_pkg and the unit's RTL; a small class mirrors the queue.

module tb_deadline_ordered_timer_queue_unit;
  import dotq_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 284;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned TAIL_CYCLES  = MAX_RESULTS + 4;
  localparam logic [TIME_BITS-1:0] TIME_TOP = {TIME_BITS{1'b1}};
  localparam logic [TMO_BITS-1:0]  TMO_TOP  = {TMO_BITS{1'b1}};

  // Mirror of the pending-task store; builds the expected timer reports
  // and releases for each accepted transaction.
  class timer_queue_mirror;
    logic [TIME_BITS-1:0] due_at [QUEUE_DEPTH];
    logic [TASK_BITS-1:0] owner  [QUEUE_DEPTH];
    int unsigned          fill;
    bit                   timer_on;
    res_t                 awaited_res [$];
    int unsigned          fail_count;

    function logic [TIME_BITS-1:0] time_left(logic [TIME_BITS-1:0] dl,
                                             logic [TIME_BITS-1:0] now);
      return (dl > now) ? dl - now : '0;
    endfunction

    // Append one expected result at the tail of the wait list.
    function void add_awaited(res_t r);
      awaited_res = {awaited_res, r};
    endfunction

    function void take_cmd(cmd_t c);
      res_t                 r;
      logic [TIME_BITS:0]   sum;
      logic [TIME_BITS-1:0] dl;
      logic [TASK_BITS-1:0] released [MAX_RESULTS];
      bit                   wake;
      int unsigned          pos;
      int unsigned          n;
      r = '0;
      if (c.op == OP_SCHEDULE) begin
        r.last = 1'b1;
        if (fill == QUEUE_DEPTH) begin
          // Full store: drop the transaction, leave the state alone.
          r.rejected = 1'b1;
          r.armed    = timer_on;
          add_awaited(r);
          return;
        end
        sum  = {1'b0, c.now_ms} + {{(TIME_BITS + 1 - TMO_BITS){1'b0}}, c.timeout_ms};
        dl   = sum[TIME_BITS] ? TIME_TOP : sum[TIME_BITS-1:0];
        // Compare against the head before the insert.
        wake = !timer_on || fill == 0 || dl < due_at[0];
        pos  = fill;
        while (pos > 0 && due_at[pos-1] > dl) pos--;
        for (int unsigned i = fill; i > pos; i--) begin
          due_at[i] = due_at[i-1];
          owner[i]  = owner[i-1];
        end
        due_at[pos] = dl;
        owner[pos]  = c.task_id;
        fill++;
        if (wake) begin
          timer_on        = 1'b1;
          r.rearm         = 1'b1;
          r.next_delay_ms = time_left(due_at[0], c.now_ms);
        end
        r.armed = timer_on;
        add_awaited(r);
      end else begin
        n = 0;
        while (n < fill && n < MAX_RESULTS && due_at[n] <= c.now_ms) begin
          released[n] = owner[n];
          n++;
        end
        for (int unsigned i = n; i < fill; i++) begin
          due_at[i-n] = due_at[i];
          owner[i-n]  = owner[i];
        end
        fill    -= n;
        timer_on = (fill != 0);
        r.armed  = timer_on;
        // Earlier releases carry only the task and the armed flag.
        for (int unsigned k = 0; k + 1 < n; k++) begin
          r.task_valid = 1'b1;
          r.ready_task = released[k];
          add_awaited(r);
        end
        r.task_valid    = (n != 0);
        r.ready_task    = (n != 0) ? released[n-1] : '0;
        r.rearm         = timer_on;
        r.next_delay_ms = timer_on ? time_left(due_at[0], c.now_ms) : '0;
        r.last          = 1'b1;
        add_awaited(r);
      end
    endfunction

    function void check_field(string name, logic [TIME_BITS-1:0] want,
                              logic [TIME_BITS-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited_res.size() == 0) begin
        $error("result 0x%0h with no transaction waiting", got);
        fail_count++;
        return;
      end
      want = awaited_res.pop_front();
      check_field("task_valid", TIME_BITS'(want.task_valid), TIME_BITS'(got.task_valid));
      check_field("ready_task", TIME_BITS'(want.ready_task), TIME_BITS'(got.ready_task));
      check_field("rearm", TIME_BITS'(want.rearm), TIME_BITS'(got.rearm));
      check_field("next_delay_ms", want.next_delay_ms, got.next_delay_ms);
      check_field("armed", TIME_BITS'(want.armed), TIME_BITS'(got.armed));
      check_field("rejected", TIME_BITS'(want.rejected), TIME_BITS'(got.rejected));
      check_field("last", TIME_BITS'(want.last), TIME_BITS'(got.last));
    endfunction
  endclass

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  cmd_t        cmd_i  = '0;
  logic        busy;
  logic        res_valid_o;
  res_t        res_o;

  timer_queue_mirror    mirror;
  logic [TIME_BITS-1:0] tick;
  int unsigned          cycle_count = 0;

  deadline_ordered_timer_queue_unit #(
    .CAPACITY(QUEUE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .cmd_i      (cmd_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Results cannot be held off: check each one at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) mirror.check_result(res_o);
  end

  function automatic logic [TIME_BITS-1:0] rand_time();
    logic [31:0] hi;
    logic [31:0] lo;
    hi = $urandom();
    lo = $urandom();
    return {hi[TIME_BITS-33:0], lo};
  endfunction

  function automatic logic [TMO_BITS-1:0] rand_timeout();
    logic [31:0] raw;
    raw = $urandom();
    return raw[TMO_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] step_time(logic [TIME_BITS-1:0] t,
                                                     int unsigned step);
    return (t > TIME_TOP - step) ? TIME_TOP : t + step;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic cmd_t make_cmd(logic op, logic [TASK_BITS-1:0] id,
                                    logic [TMO_BITS-1:0] tmo,
                                    logic [TIME_BITS-1:0] now);
    cmd_t c;
    c.op         = op;
    c.task_id    = id;
    c.timeout_ms = tmo;
    c.now_ms     = now;
    return c;
  endfunction

  // Present one transaction, hold it until the unit takes it, then record it.
  task automatic push_cmd(input cmd_t c, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    mirror.take_cmd(c);
  endtask

  // Stop sending until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    while (mirror.awaited_res.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    // Fire on an empty store with the timer idle.
    push_cmd(make_cmd(OP_FIRE, 8'h00, '0, '0), pick_gap(0));
    // Zero timeout at time zero, then a saturated deadline at the top of time.
    push_cmd(make_cmd(OP_SCHEDULE, 8'h00, '0, '0), pick_gap(0));
    push_cmd(make_cmd(OP_SCHEDULE, 8'hFF, TMO_TOP, TIME_TOP), pick_gap(0));
    push_cmd(make_cmd(OP_FIRE, 8'hFF, TMO_TOP, '0), pick_gap(0));
    // Tie at 120 kept in arrival order, then a new earliest at 105.
    push_cmd(make_cmd(OP_SCHEDULE, 8'h11, TMO_BITS'(20), TIME_BITS'(100)), pick_gap(0));
    push_cmd(make_cmd(OP_SCHEDULE, 8'h22, TMO_BITS'(10), TIME_BITS'(110)), pick_gap(0));
    push_cmd(make_cmd(OP_SCHEDULE, 8'h33, TMO_BITS'(5), TIME_BITS'(100)), pick_gap(0));
    // Nothing due yet, then three due at once.
    push_cmd(make_cmd(OP_FIRE, 8'h00, '0, TIME_BITS'(104)), pick_gap(0));
    push_cmd(make_cmd(OP_FIRE, 8'h00, '0, TIME_BITS'(120)), pick_gap(0));
    // Fill the store with paired ties, overflow it, then release everything.
    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
      push_cmd(make_cmd(OP_SCHEDULE, TASK_BITS'(8'h40 + i), TMO_BITS'((i / 2) * 3),
                        TIME_BITS'(200)), pick_gap(0));
    push_cmd(make_cmd(OP_SCHEDULE, 8'hEE, TMO_BITS'(1), TIME_BITS'(200)), pick_gap(0));
    push_cmd(make_cmd(OP_FIRE, 8'h00, '0, TIME_TOP), pick_gap(0));
  endtask

  // Episodes around a moving time base: a mix of schedules, mostly with short
  // timeouts, and fires a little later, with some noise mixed in.
  task automatic run_random();
    int unsigned sent;
    int unsigned sched_pct;
    int unsigned len;
    int unsigned roll;
    bit          steady;
    cmd_t        c;
    logic [TMO_BITS-1:0] tmo;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) tick = TIME_BITS'($urandom_range(0, 1000));
      else if (roll < 85) tick = rand_time();
      else tick = TIME_TOP - TIME_BITS'($urandom_range(0, 200));
      sched_pct = $urandom_range(30, 90);
      steady    = ($urandom_range(0, 3) == 0);
      len       = $urandom_range(5, 30);
      for (int unsigned j = 0; j < len && sent < RANDOM_ITEMS; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          c = make_cmd(1'($urandom_range(0, 1)), TASK_BITS'($urandom_range(0, 255)),
                       rand_timeout(), rand_time());
        end else if (roll < 8 + sched_pct * 92 / 100) begin
          tick = step_time(tick, $urandom_range(0, 3));
          roll = $urandom_range(0, 99);
          if (roll < 85) tmo = TMO_BITS'($urandom_range(0, 60));
          else if (roll < 95) tmo = TMO_BITS'($urandom_range(0, 5000));
          else tmo = rand_timeout();
          c = make_cmd(OP_SCHEDULE, TASK_BITS'($urandom_range(0, 255)), tmo, tick);
        end else begin
          tick = step_time(tick, $urandom_range(0, 40));
          c = make_cmd(OP_FIRE, TASK_BITS'($urandom_range(0, 255)), rand_timeout(), tick);
        end
        push_cmd(c, pick_gap(steady));
        sent++;
      end
      if ($urandom_range(0, 4) == 0) drain();
    end
  endtask

  initial begin
    mirror = new();
    tick   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    drain();
    run_random();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mirror.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> deadline_ordered_timer_queue_unit.f
rtl/core/dotq_pkg.sv
rtl/core/dotq_cell.sv
rtl/core/deadline_ordered_timer_queue_unit.sv
sim/tb_deadline_ordered_timer_queue_unit.sv
